### hdl/sam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_pkg
// Shared constants and types for the suffix automaton builder.
// ----------------------------------------------------------------------------
package sam_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int ALPHABET  = 26;
    localparam int CAPACITY  = 2 * MAX_LEN;
    localparam int ST_W      = $clog2(CAPACITY);
    localparam int CNT_W     = ST_W + 1;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int SYM_W     = 5;
    localparam int COL_W     = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int TT_DEPTH  = CAPACITY * ALPHABET;
    localparam int TT_AW     = $clog2(TT_DEPTH);
    localparam int OUT_ST_W  = 11;
    localparam int OUT_LEN_W = 11;
    localparam int OUT_CNT_W = 12;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             restart;
    } sam_in_t;

    typedef struct packed {
        logic [OUT_ST_W-1:0]  new_state;
        logic [OUT_LEN_W-1:0] new_length;
        logic [OUT_ST_W-1:0]  link_target;
        logic                 cloned;
        logic [OUT_ST_W-1:0]  clone_state;
        logic [OUT_LEN_W-1:0] clone_length;
        logic [OUT_CNT_W-1:0] state_total;
        logic                 overflow;
    } sam_out_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR_R,
        S_CHK_RD,
        S_CHK,
        S_CLR_X,
        S_W1_RD,
        S_W1_CHK,
        S_Q_RD,
        S_Q_CHK,
        S_CP_RD,
        S_CP_WR,
        S_CP_FIN,
        S_W2_RD,
        S_W2_CHK,
        S_DONE
    } sam_state_t;

    // Table memory request.
    typedef struct packed {
        logic             tt_we;
        logic [TT_AW-1:0] tt_addr;
        logic [ST_W-1:0]  tt_wdata;
    } sam_tt_req_t;

endpackage

### hdl/sam_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_in_if / sam_out_if
// Valid/ready request channels for input symbols and results.
// ----------------------------------------------------------------------------
interface sam_in_if import sam_pkg::*;;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             restart;
    modport source (output valid, output symbol, output restart, input ready);
    modport sink   (input valid, input symbol, input restart, output ready);
endinterface

interface sam_out_if import sam_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OUT_ST_W-1:0]  new_state;
    logic [OUT_LEN_W-1:0] new_length;
    logic [OUT_ST_W-1:0]  link_target;
    logic                 cloned;
    logic [OUT_ST_W-1:0]  clone_state;
    logic [OUT_LEN_W-1:0] clone_length;
    logic [OUT_CNT_W-1:0] state_total;
    logic                 overflow;
    modport source (output valid, output new_state, output new_length,
                    output link_target, output cloned, output clone_state,
                    output clone_length, output state_total, output overflow,
                    input ready);
    modport sink   (input valid, input new_state, input new_length,
                    input link_target, input cloned, input clone_state,
                    input clone_length, input state_total, input overflow,
                    output ready);
endinterface

### hdl/sam_trans_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_trans_mem
// Transition table memory, one synchronous port; rows are written on allocation.
// ----------------------------------------------------------------------------
module sam_trans_mem
    import sam_pkg::*;
(
    input  logic            clk,
    input  sam_tt_req_t     req,
    output logic [ST_W-1:0] rdata
);

    logic [ST_W-1:0] mem [TT_DEPTH];
    logic [ST_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.tt_we)
        begin
            mem[req.tt_addr] <= req.tt_wdata;
        end
        rd_reg <= mem[req.tt_addr];
    end

    assign rdata = rd_reg;

endmodule

### hdl/sam_node_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_node_mem
// Per-state length and suffix link memory, one synchronous read port.
// ----------------------------------------------------------------------------
module sam_node_mem
    import sam_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [ST_W-1:0]  waddr,
    input  logic [LEN_W-1:0] wlen,
    input  logic [CNT_W-1:0] wlink,
    input  logic [ST_W-1:0]  raddr,
    output logic [LEN_W-1:0] rlen,
    output logic [CNT_W-1:0] rlink
);

    logic [LEN_W+CNT_W-1:0] mem [CAPACITY];
    logic [LEN_W+CNT_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wlen, wlink};
        end
        rd_reg <= mem[raddr];
    end

    assign rlen  = rd_reg[LEN_W+CNT_W-1:CNT_W];
    assign rlink = rd_reg[CNT_W-1:0];

endmodule

### hdl/suffix_automaton_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_builder
// Online suffix automaton construction, one symbol per request.
// ----------------------------------------------------------------------------
// channel | dir | fields
// in_ch   | in  | symbol[4:0], restart
// out_ch  | out | new_state, new_length, link_target, cloned, clone_state,
//         |     | clone_length, state_total[11:0], overflow
//
// One request at a time. Steps: clear the root row on restart or empty
// automaton, check, clear the new row, read and test per link step of each
// walk, test q, copy the row for a clone, finish. Bound by the single table
// port.
// Reset leaves an empty automaton; every row is cleared or copied when it is
// allocated, so no table entry is read before it is written.
// Output register: next request is taken while a result waits to be taken.
// ----------------------------------------------------------------------------
module suffix_automaton_builder
    import sam_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    sam_in_if.sink  in_ch,
    sam_out_if.source out_ch
);

    localparam logic [CNT_W-1:0] NO_LINK = '1;

    sam_state_t state_reg, state_next;

    logic [SYM_W-1:0] sym_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ST_W-1:0]  last_reg, last_next;
    logic [LEN_W-1:0] last_len_reg, last_len_next;
    logic [CNT_W-1:0] last_link_reg, last_link_next;
    logic [ST_W-1:0]  x_reg, x_next;
    logic [CNT_W-1:0] p_reg, p_next;
    logic [ST_W-1:0]  q_reg, q_next;
    logic [ST_W-1:0]  r_reg, r_next;
    logic [LEN_W-1:0] plen_reg, plen_next;
    logic [CNT_W-1:0] qlink_reg, qlink_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [LEN_W-1:0] qlen_reg;
    logic             res_pend_reg, res_pend_next;

    sam_out_t res_reg, res_next;
    sam_out_t out_reg, out_next;
    logic     ovalid_reg, ovalid_next;

    sam_tt_req_t      tt_req;
    logic [ST_W-1:0]  tt_rdata;
    logic             nm_we;
    logic [ST_W-1:0]  nm_waddr, nm_raddr;
    logic [LEN_W-1:0] nm_wlen, nm_rlen;
    logic [CNT_W-1:0] nm_wlink, nm_rlink;

    logic             accept;
    logic             empty_now;

    sam_trans_mem u_tt (.clk(clk), .req(tt_req), .rdata(tt_rdata));

    sam_node_mem u_nm (
        .clk(clk), .we(nm_we), .waddr(nm_waddr), .wlen(nm_wlen), .wlink(nm_wlink),
        .raddr(nm_raddr), .rlen(nm_rlen), .rlink(nm_rlink)
    );

    assign in_ch.ready = (state_reg == S_IDLE) && !res_pend_reg;
    assign accept      = in_ch.valid && in_ch.ready;
    assign empty_now   = in_ch.restart || (cnt_reg == '0);

    function automatic logic [TT_AW-1:0] taddr(input logic [ST_W-1:0] st,
                                               input logic [COL_W-1:0] c);
        taddr = TT_AW'(st) * TT_AW'(ALPHABET) + TT_AW'(c);
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = empty_now ? S_CLR_R : S_CHK_RD;
            S_CLR_R:  if (col_reg == COL_W'(ALPHABET - 1)) state_next = S_CHK_RD;
            S_CHK_RD: state_next = S_CHK;
            S_CHK:
            begin
                if ((sym_reg >= SYM_W'(ALPHABET)) ||
                    (32'(last_len_reg) + 1 > MAX_LEN) ||
                    (32'(cnt_reg) + 2 > CAPACITY))
                    state_next = S_DONE;
                else
                    state_next = S_CLR_X;
            end
            S_CLR_X:  if (col_reg == COL_W'(ALPHABET - 1)) state_next = S_W1_RD;
            S_W1_RD:  state_next = S_W1_CHK;
            S_W1_CHK:
            begin
                if (tt_rdata != '0)               state_next = S_Q_RD;
                else if (nm_rlink == NO_LINK)     state_next = S_DONE;
                else                              state_next = S_W1_RD;
            end
            S_Q_RD:   state_next = S_Q_CHK;
            S_Q_CHK:
            begin
                if (plen_reg + LEN_W'(1) == nm_rlen) state_next = S_DONE;
                else                                 state_next = S_CP_RD;
            end
            S_CP_RD:  state_next = S_CP_WR;
            S_CP_WR:
            begin
                if (col_reg == COL_W'(ALPHABET - 1)) state_next = S_CP_FIN;
                else                                 state_next = S_CP_RD;
            end
            S_CP_FIN: state_next = S_W2_RD;
            S_W2_RD:  state_next = S_W2_CHK;
            S_W2_CHK:
            begin
                if (tt_rdata != q_reg || nm_rlink == NO_LINK) state_next = S_DONE;
                else                                          state_next = S_W2_RD;
            end
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        last_len_next  = last_len_reg;
        last_link_next = last_link_reg;
        x_next         = x_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        plen_next      = plen_reg;
        qlink_next     = qlink_reg;
        col_next       = col_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        ovalid_next    = ovalid_reg;
        res_pend_next  = res_pend_reg;
        tt_req         = '0;
        nm_we          = 1'b0;
        nm_waddr       = '0;
        nm_wlen        = '0;
        nm_wlink       = '0;
        nm_raddr       = ST_W'(p_reg);

        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end
        if (res_pend_reg && (!ovalid_reg || out_ch.ready))
        begin
            ovalid_next   = 1'b1;
            out_next      = res_reg;
            res_pend_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                col_next = '0;
                if (accept && empty_now)
                begin
                    // root only; its row is cleared in S_CLR_R
                    nm_we          = 1'b1;
                    nm_waddr       = '0;
                    nm_wlen        = '0;
                    nm_wlink       = NO_LINK;
                    cnt_next       = CNT_W'(1);
                    last_next      = '0;
                    last_len_next  = '0;
                    last_link_next = NO_LINK;
                end
            end
            S_CLR_R:
            begin
                tt_req.tt_we    = 1'b1;
                tt_req.tt_addr  = taddr('0, col_reg);
                tt_req.tt_wdata = '0;
                col_next        = col_reg + COL_W'(1);
            end
            S_CHK_RD:
            begin
                col_next = '0;
            end
            S_CHK:
            begin
                x_next = ST_W'(cnt_reg);
                p_next = CNT_W'(last_reg);
                if (!((sym_reg >= SYM_W'(ALPHABET)) ||
                      (32'(last_len_reg) + 1 > MAX_LEN) ||
                      (32'(cnt_reg) + 2 > CAPACITY)))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    nm_we    = 1'b1;
                    nm_waddr = ST_W'(cnt_reg);
                    nm_wlen  = last_len_reg + LEN_W'(1);
                    nm_wlink = '0;
                end
                res_next.overflow  = (sym_reg < SYM_W'(ALPHABET));
                res_next.new_state = OUT_ST_W'(last_reg);
                res_next.new_length = OUT_LEN_W'(last_len_reg);
                res_next.link_target = (last_link_reg == NO_LINK) ? '0
                                       : OUT_ST_W'(last_link_reg);
                res_next.cloned       = 1'b0;
                res_next.clone_state  = '0;
                res_next.clone_length = '0;
                res_next.state_total  = OUT_CNT_W'(cnt_reg);
            end
            S_CLR_X:
            begin
                tt_req.tt_we    = 1'b1;
                tt_req.tt_addr  = taddr(x_reg, col_reg);
                tt_req.tt_wdata = '0;
                col_next        = col_reg + COL_W'(1);
                if (col_reg == COL_W'(ALPHABET - 1))
                begin
                    col_next              = '0;
                    res_next.overflow     = 1'b0;
                    res_next.new_state    = OUT_ST_W'(x_reg);
                    res_next.new_length   = OUT_LEN_W'(last_len_reg + LEN_W'(1));
                    res_next.link_target  = '0;
                    res_next.state_total  = OUT_CNT_W'(cnt_reg);
                    last_next             = x_reg;
                    last_len_next         = last_len_reg + LEN_W'(1);
                    last_link_next        = '0;
                end
            end
            S_W1_RD, S_W2_RD:
            begin
                tt_req.tt_addr = taddr(ST_W'(p_reg), COL_W'(sym_reg));
                nm_raddr       = ST_W'(p_reg);
            end
            S_W1_CHK:
            begin
                if (tt_rdata != '0)
                begin
                    q_next    = tt_rdata;
                    plen_next = nm_rlen;
                end
                else
                begin
                    tt_req.tt_we    = 1'b1;
                    tt_req.tt_addr  = taddr(ST_W'(p_reg), COL_W'(sym_reg));
                    tt_req.tt_wdata = x_reg;
                    p_next          = nm_rlink;
                end
            end
            S_Q_RD:
            begin
                nm_raddr = q_reg;
            end
            S_Q_CHK:
            begin
                qlink_next = nm_rlink;
                r_next     = ST_W'(cnt_reg);
                if (plen_reg + LEN_W'(1) == nm_rlen)
                begin
                    nm_we    = 1'b1;
                    nm_waddr = x_reg;
                    nm_wlen  = last_len_reg;
                    nm_wlink = CNT_W'(q_reg);
                    last_link_next       = CNT_W'(q_reg);
                    res_next.link_target = OUT_ST_W'(q_reg);
                end
                else
                begin
                    // x links to the clone, which takes the next free index
                    nm_we    = 1'b1;
                    nm_waddr = x_reg;
                    nm_wlen  = last_len_reg;
                    nm_wlink = cnt_reg;
                    cnt_next = cnt_reg + CNT_W'(1);
                    col_next = '0;
                end
            end
            S_CP_RD:
            begin
                tt_req.tt_addr = taddr(q_reg, col_reg);
            end
            S_CP_WR:
            begin
                tt_req.tt_we    = 1'b1;
                tt_req.tt_addr  = taddr(r_reg, col_reg);
                tt_req.tt_wdata = tt_rdata;
                col_next        = col_reg + COL_W'(1);
            end
            S_CP_FIN:
            begin
                // clone node; q's link goes to the clone when the walk is done
                nm_we    = 1'b1;
                nm_waddr = r_reg;
                nm_wlen  = plen_reg + LEN_W'(1);
                nm_wlink = qlink_reg;
                res_next.cloned       = 1'b1;
                res_next.clone_state  = OUT_ST_W'(r_reg);
                res_next.clone_length = OUT_LEN_W'(plen_reg + LEN_W'(1));
                res_next.link_target  = OUT_ST_W'(r_reg);
                res_next.state_total  = OUT_CNT_W'(cnt_reg);
                last_link_next        = CNT_W'(r_reg);
            end
            S_W2_CHK:
            begin
                if (tt_rdata == q_reg)
                begin
                    tt_req.tt_we    = 1'b1;
                    tt_req.tt_addr  = taddr(ST_W'(p_reg), COL_W'(sym_reg));
                    tt_req.tt_wdata = r_reg;
                    p_next          = nm_rlink;
                end
            end
            S_DONE:
            begin
                res_pend_next = 1'b1;
                if (res_reg.cloned)
                begin
                    nm_we    = 1'b1;
                    nm_waddr = q_reg;
                    nm_wlen  = qlen_reg;
                    nm_wlink = CNT_W'(r_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= (accept) ? in_ch.symbol : sym_reg;
        if (state_reg == S_Q_CHK)
        begin
            qlen_reg <= nm_rlen;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            last_reg      <= '0;
            last_len_reg  <= '0;
            last_link_reg <= NO_LINK;
            ovalid_reg    <= 1'b0;
            res_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            last_len_reg  <= last_len_next;
            last_link_reg <= last_link_next;
            ovalid_reg    <= ovalid_next;
            res_pend_reg  <= res_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        plen_reg  <= plen_next;
        qlink_reg <= qlink_next;
        col_reg   <= col_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.new_state    = out_reg.new_state;
    assign out_ch.new_length   = out_reg.new_length;
    assign out_ch.link_target  = out_reg.link_target;
    assign out_ch.cloned       = out_reg.cloned;
    assign out_ch.clone_state  = out_reg.clone_state;
    assign out_ch.clone_length = out_reg.clone_length;
    assign out_ch.state_total  = out_reg.state_total;
    assign out_ch.overflow     = out_reg.overflow;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= CAPACITY) else $error("state count above capacity");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE) else $error("ready while busy");
    a_clone_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.cloned) |-> !out_ch.overflow)
        else $error("clone with overflow");
`endif

endmodule
